[rtl/core/tmq_pkg.sv]
// Shared types and constants for the timer min-queue block.
// Used by the controller, the datapath, the top level and the checker.
package tmq_pkg;

  // Capacity of the timer list and the widths that follow from it.
  localparam int DEPTH = 64;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  // Field widths of one word.
  localparam int CMD_W  = 2;
  localparam int DUR_W  = 31;
  localparam int TAG_W  = 16;
  localparam int LEFT_W = 32;
  localparam int STS_W  = 2;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_PUSH    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POP     = 2'd1;
  localparam logic [CMD_W-1:0] CMD_ADVANCE = 2'd2;

  // Result status codes.
  localparam logic [STS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STS_W-1:0] ST_FULL  = 2'd2;

  // One stored timer.
  typedef struct packed {
    logic signed [LEFT_W-1:0] left;
    logic [DUR_W-1:0]         dur;
    logic [TAG_W-1:0]         tag;
  } tmq_entry_t;

  localparam int ENT_W = $bits(tmq_entry_t);

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_POP_CAP,
    S_SCAN,
    S_FINISH
  } tmq_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic decode;
    logic push_wr;
    logic pop_rd;
    logic pop_cap;
    logic scan_start;
    logic scan_step;
    logic finish;
  } tmq_ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             full;
    logic             empty;
    logic             one_left;
    logic             scan_last;
    logic             out_free;
  } tmq_sts_t;

endpackage

[rtl/core/tmq_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module tmq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/tmq_ctrl.sv]
// Controller state machine for the timer min-queue.
// Depends on tmq_pkg; drives tmq_datapath through tmq_ctl_t.
module tmq_ctrl
  import tmq_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  tmq_sts_t   sts,
  output tmq_ctl_t   ctl
);

  tmq_state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        case (sts.cmd)
          CMD_POP:     state_nxt = sts.empty ? S_FINISH : S_POP_CAP;
          CMD_ADVANCE: state_nxt = sts.empty ? S_FINISH : S_SCAN;
          default:     state_nxt = S_FINISH;
        endcase
      end
      S_POP_CAP: begin
        state_nxt = sts.one_left ? S_FINISH : S_SCAN;
      end
      S_SCAN: begin
        if (sts.scan_last) state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    ctl      = '0;
    in_stall = 1'b1;
    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        ctl.load = in_valid;
      end
      S_DECODE: begin
        ctl.decode = 1'b1;
        case (sts.cmd)
          CMD_PUSH:    ctl.push_wr    = !sts.full;
          CMD_POP:     ctl.pop_rd     = !sts.empty;
          CMD_ADVANCE: ctl.scan_start = !sts.empty;
          default:     ctl.decode     = 1'b1;
        endcase
      end
      S_POP_CAP: begin
        ctl.pop_cap    = 1'b1;
        ctl.scan_start = !sts.one_left;
      end
      S_SCAN: begin
        ctl.scan_step = 1'b1;
      end
      S_FINISH: begin
        ctl.finish = sts.out_free;
      end
      default: in_stall = 1'b1;
    endcase
  end

endmodule

[rtl/core/tmq_datapath.sv]
// Datapath of the timer min-queue: timer store, count, minimum tracking,
// the compact/advance scan and the output register.
// Depends on tmq_pkg and tmq_ram; controlled by tmq_ctrl.
module tmq_datapath
  import tmq_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  tmq_ctl_t                 ctl,
  output tmq_sts_t                 sts,
  input  logic [CMD_W-1:0]         in_cmd,
  input  logic [DUR_W-1:0]         in_duration,
  input  logic [TAG_W-1:0]         in_tag,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [STS_W-1:0]         out_status,
  output logic [TAG_W-1:0]         out_popped_tag,
  output logic [DUR_W-1:0]         out_popped_duration,
  output logic signed [LEFT_W-1:0] out_popped_left,
  output logic [CNT_W-1:0]         out_entry_count,
  output logic signed [LEFT_W-1:0] out_soonest_left
);

  // Latched command word.
  logic [CMD_W-1:0] cmd_r, cmd_nxt;
  logic [DUR_W-1:0] dur_r, dur_nxt;
  logic [TAG_W-1:0] tag_r, tag_nxt;

  // Queue bookkeeping.
  logic [CNT_W-1:0]         count_r, count_nxt;
  logic [IDX_W-1:0]         slot_r, slot_nxt;
  logic signed [LEFT_W-1:0] val_r, val_nxt;
  logic [IDX_W-1:0]         pop_slot_r, pop_slot_nxt;

  // Scan pipeline: read issue index and the pending write-back stage.
  logic [CNT_W-1:0] rd_i_r, rd_i_nxt;
  logic             pend_v_r, pend_v_nxt;
  logic [IDX_W-1:0] pend_i_r, pend_i_nxt;

  // Result being built.
  logic [STS_W-1:0]         res_status_r, res_status_nxt;
  logic [TAG_W-1:0]         res_tag_r, res_tag_nxt;
  logic [DUR_W-1:0]         res_dur_r, res_dur_nxt;
  logic signed [LEFT_W-1:0] res_left_r, res_left_nxt;

  // Output register.
  logic                     out_valid_r, out_valid_nxt;
  logic [STS_W-1:0]         out_status_r, out_status_nxt;
  logic [TAG_W-1:0]         out_tag_r, out_tag_nxt;
  logic [DUR_W-1:0]         out_dur_r, out_dur_nxt;
  logic signed [LEFT_W-1:0] out_left_r, out_left_nxt;
  logic [CNT_W-1:0]         out_count_r, out_count_nxt;
  logic signed [LEFT_W-1:0] out_soon_r, out_soon_nxt;

  // RAM ports.
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  tmq_entry_t       ram_wdata;
  logic [IDX_W-1:0] ram_raddr;
  tmq_entry_t       ram_rdata;

  // Scan helpers.
  logic                     is_pop;
  logic [CNT_W-1:0]         scan_addr;
  logic signed [LEFT_W:0]   diff;
  logic signed [LEFT_W-1:0] new_left;
  logic                     take_best;
  logic signed [LEFT_W-1:0] push_left;

  tmq_ram #(
    .WIDTH (ENT_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Read address: the popped slot, or the next scan slot skipping the gap on pop.
  assign is_pop    = (cmd_r == CMD_POP);
  assign scan_addr = (is_pop && (rd_i_r >= {1'b0, pop_slot_r})) ? rd_i_r + CNT_W'(1) : rd_i_r;
  assign ram_raddr = ctl.pop_rd ? slot_r : scan_addr[IDX_W-1:0];

  // Saturating subtract of the elapsed time.
  assign diff     = {ram_rdata.left[LEFT_W-1], ram_rdata.left} - {2'b00, dur_r};
  assign new_left = is_pop ? ram_rdata.left
                  : ((diff[LEFT_W] != diff[LEFT_W-1]) ? {1'b1, {(LEFT_W-1){1'b0}}}
                                                      : diff[LEFT_W-1:0]);
  assign take_best = (pend_i_r == '0) || (new_left < val_r);
  assign push_left = {1'b0, dur_r};

  // Write port: append on push, write back each scanned slot.
  always_comb begin
    ram_we         = ctl.push_wr || (ctl.scan_step && pend_v_r);
    ram_waddr      = pend_i_r;
    ram_wdata.left = new_left;
    ram_wdata.dur  = ram_rdata.dur;
    ram_wdata.tag  = ram_rdata.tag;
    if (ctl.push_wr) begin
      ram_waddr      = count_r[IDX_W-1:0];
      ram_wdata.left = push_left;
      ram_wdata.dur  = dur_r;
      ram_wdata.tag  = tag_r;
    end
  end

  // Command latch and result status.
  always_comb begin
    cmd_nxt        = cmd_r;
    dur_nxt        = dur_r;
    tag_nxt        = tag_r;
    res_status_nxt = res_status_r;
    res_tag_nxt    = res_tag_r;
    res_dur_nxt    = res_dur_r;
    res_left_nxt   = res_left_r;
    pop_slot_nxt   = pop_slot_r;
    if (ctl.load) begin
      cmd_nxt      = in_cmd;
      dur_nxt      = in_duration;
      tag_nxt      = in_tag;
      res_tag_nxt  = '0;
      res_dur_nxt  = '0;
      res_left_nxt = '0;
    end
    if (ctl.decode) begin
      res_status_nxt = ST_DONE;
      if (cmd_r == CMD_PUSH && sts.full)  res_status_nxt = ST_FULL;
      if (cmd_r == CMD_POP  && sts.empty) res_status_nxt = ST_EMPTY;
    end
    if (ctl.pop_rd) begin
      pop_slot_nxt = slot_r;
    end
    if (ctl.pop_cap) begin
      res_tag_nxt  = ram_rdata.tag;
      res_dur_nxt  = ram_rdata.dur;
      res_left_nxt = ram_rdata.left;
    end
  end

  // Count and minimum tracking.
  always_comb begin
    count_nxt = count_r;
    slot_nxt  = slot_r;
    val_nxt   = val_r;
    if (ctl.push_wr) begin
      count_nxt = count_r + CNT_W'(1);
      if (count_r == '0) begin
        slot_nxt = '0;
        val_nxt  = push_left;
      end else if (push_left < val_r) begin
        slot_nxt = count_r[IDX_W-1:0];
        val_nxt  = push_left;
      end
    end
    if (ctl.pop_cap) begin
      count_nxt = count_r - CNT_W'(1);
      if (sts.one_left) begin
        slot_nxt = '0;
        val_nxt  = '0;
      end
    end
    if (ctl.scan_step && pend_v_r && take_best) begin
      slot_nxt = pend_i_r;
      val_nxt  = new_left;
    end
  end

  // Scan sequencing: one read issued and one slot written back per cycle.
  always_comb begin
    rd_i_nxt   = rd_i_r;
    pend_v_nxt = pend_v_r;
    pend_i_nxt = pend_i_r;
    if (ctl.scan_start) begin
      rd_i_nxt   = '0;
      pend_v_nxt = 1'b0;
    end else if (ctl.scan_step) begin
      if (rd_i_r < count_r) begin
        rd_i_nxt   = rd_i_r + CNT_W'(1);
        pend_v_nxt = 1'b1;
        pend_i_nxt = rd_i_r[IDX_W-1:0];
      end else begin
        pend_v_nxt = 1'b0;
      end
    end
  end

  // Output register: loaded at finish, freed when the word is taken.
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_tag_nxt    = out_tag_r;
    out_dur_nxt    = out_dur_r;
    out_left_nxt   = out_left_r;
    out_count_nxt  = out_count_r;
    out_soon_nxt   = out_soon_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (ctl.finish) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = res_status_r;
      out_tag_nxt    = res_tag_r;
      out_dur_nxt    = res_dur_r;
      out_left_nxt   = res_left_r;
      out_count_nxt  = count_r;
      out_soon_nxt   = (count_r == '0) ? '0 : val_r;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      slot_r      <= '0;
      val_r       <= '0;
      pend_v_r    <= 1'b0;
      rd_i_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      slot_r      <= slot_nxt;
      val_r       <= val_nxt;
      pend_v_r    <= pend_v_nxt;
      rd_i_r      <= rd_i_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    dur_r        <= dur_nxt;
    tag_r        <= tag_nxt;
    pop_slot_r   <= pop_slot_nxt;
    pend_i_r     <= pend_i_nxt;
    res_status_r <= res_status_nxt;
    res_tag_r    <= res_tag_nxt;
    res_dur_r    <= res_dur_nxt;
    res_left_r   <= res_left_nxt;
    out_status_r <= out_status_nxt;
    out_tag_r    <= out_tag_nxt;
    out_dur_r    <= out_dur_nxt;
    out_left_r   <= out_left_nxt;
    out_count_r  <= out_count_nxt;
    out_soon_r   <= out_soon_nxt;
  end

  // Status to the controller.
  assign sts.cmd       = cmd_r;
  assign sts.full      = (count_r == CNT_W'(DEPTH));
  assign sts.empty     = (count_r == '0);
  assign sts.one_left  = (count_r == CNT_W'(1));
  assign sts.scan_last = pend_v_r && ({1'b0, pend_i_r} == count_r - CNT_W'(1));
  assign sts.out_free  = !out_valid_r || !out_stall;

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_popped_tag      = out_tag_r;
  assign out_popped_duration = out_dur_r;
  assign out_popped_left     = out_left_r;
  assign out_entry_count     = out_count_r;
  assign out_soonest_left    = out_soon_r;

endmodule

[rtl/core/timer_min_queue.sv]
// Top level of the timer min-queue: controller plus datapath.
// Depends on tmq_pkg, tmq_ctrl, tmq_datapath (and tmq_ram below it).
//
// Holds up to DEPTH (64) timers in insertion order and answers every command
// word with exactly one result word. A push, and any command that leaves the
// list alone, has its result word ready without a walk of the list. A pop or
// an advance walks the list first, and a pop of the last timer skips the walk.
// Both walk the timer RAM one slot per cycle through its single read port and
// single write port, closing the gap (pop) or subtracting the elapsed time
// (advance) while the new minimum is tracked.
// One command is in work at a time; the result sits in an output register, so
// the next command is taken while that word waits, and that command's result
// is held back until the waiting word has been taken.
// Timer storage is not cleared at reset; only slots below the count are read.
module timer_min_queue
  import tmq_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [CMD_W-1:0]         in_cmd,
  input  logic [DUR_W-1:0]         in_duration,
  input  logic [TAG_W-1:0]         in_tag,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [STS_W-1:0]         out_status,
  output logic [TAG_W-1:0]         out_popped_tag,
  output logic [DUR_W-1:0]         out_popped_duration,
  output logic signed [LEFT_W-1:0] out_popped_left,
  output logic [CNT_W-1:0]         out_entry_count,
  output logic signed [LEFT_W-1:0] out_soonest_left
);

  tmq_ctl_t ctl;
  tmq_sts_t sts;

  // Sequencer.
  tmq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .ctl      (ctl)
  );

  // Storage, arithmetic and output register.
  tmq_datapath u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .ctl                 (ctl),
    .sts                 (sts),
    .in_cmd              (in_cmd),
    .in_duration         (in_duration),
    .in_tag              (in_tag),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_popped_tag      (out_popped_tag),
    .out_popped_duration (out_popped_duration),
    .out_popped_left     (out_popped_left),
    .out_entry_count     (out_entry_count),
    .out_soonest_left    (out_soonest_left)
  );

endmodule

[rtl/core/tmq_checker.sv]
// Port-level assertions for timer_min_queue, attached by bind.
// Depends on tmq_pkg; sees only the top-level ports.
module tmq_checker
  import tmq_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_stall,
  input logic [CMD_W-1:0]         in_cmd,
  input logic [DUR_W-1:0]         in_duration,
  input logic [TAG_W-1:0]         in_tag,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic [STS_W-1:0]         out_status,
  input logic [TAG_W-1:0]         out_popped_tag,
  input logic [DUR_W-1:0]         out_popped_duration,
  input logic signed [LEFT_W-1:0] out_popped_left,
  input logic [CNT_W-1:0]         out_entry_count,
  input logic signed [LEFT_W-1:0] out_soonest_left
);

  // A stalled result word stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result word dropped while stalled");

  // The count never exceeds the capacity.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_entry_count <= CNT_W'(DEPTH))
    else $error("entry count above capacity");

  // A rejected push only happens on a full list.
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_FULL |-> out_entry_count == CNT_W'(DEPTH))
    else $error("push rejected while not full");

  // A pop on an empty list returns nothing and leaves it empty.
  a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_EMPTY |->
      out_entry_count == '0 && out_popped_tag == '0 && out_popped_left == '0)
    else $error("empty pop returned data");

  // An empty list reports no soonest time.
  a_empty_soon: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_entry_count == '0 |-> out_soonest_left == '0)
    else $error("soonest time reported on empty list");

endmodule

bind timer_min_queue tmq_checker u_tmq_checker (.*);
